@@ src/linked_list_deque_with_key_delete_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linked list deque block
// Shared helpers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LINKED_LIST_DEQUE_WITH_KEY_DELETE_TOP_ASSERT_SVH
`define LINKED_LIST_DEQUE_WITH_KEY_DELETE_TOP_ASSERT_SVH

// same-cycle implication
`define LLDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lldq: same-cycle check failed");

// next-cycle implication
`define LLDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lldq: next-cycle check failed");

`endif

@@ src/lldq_pkg.sv @@
// ----------------------------------------------------------------------------
// lldq_pkg
// Types, codes and sizes shared by the linked list deque block.
// ----------------------------------------------------------------------------
package lldq_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_BITS = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    K_INSERT    = 3'd0,
    K_DEL_FIRST = 3'd1,
    K_DEL_LAST  = 3'd2,
    K_DEL_KEY   = 3'd3,
    K_DUMP      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [KEY_BITS-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_BITS-1:0] value;
    logic                last;
    logic [CNT_W-1:0]    count;
  } out_item_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_HEAD,
    RD_TAIL,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UNLINK,
    S_SEARCH,
    S_DUMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    logic    insert;
    logic    unlink;
    logic    idx_clr;
    logic    idx_inc;
    logic    emit;
    logic    emit_dump;
    status_t emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic key_match;
    logic walk_last;
    logic out_space;
  } dp_stat_t;

endpackage

@@ src/lldq_dp.sv @@
// ----------------------------------------------------------------------------
// lldq_dp
// Slot memories, list pointers, walk counter and the output register.
// ----------------------------------------------------------------------------
module lldq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lldq_pkg::KEY_BITS-1:0] in_key,
  input  lldq_pkg::dp_cmd_t             cmd,
  output lldq_pkg::dp_stat_t            stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output lldq_pkg::out_item_t           out_data
);
  import lldq_pkg::*;

  logic [KEY_BITS-1:0] key_store [CAPACITY];
  logic [SLOT_W-1:0]   next_link [CAPACITY];
  logic [SLOT_W-1:0]   prev_link [CAPACITY];

  logic [CAPACITY-1:0] slot_in_use_r;
  logic [SLOT_W-1:0]   head_r;
  logic [SLOT_W-1:0]   tail_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    idx_r;
  logic [KEY_BITS-1:0] key_r;

  // registered read port of the slot memories
  logic [KEY_BITS-1:0] rd_key_r;
  logic [SLOT_W-1:0]   rd_next_r;
  logic [SLOT_W-1:0]   rd_prev_r;
  logic [SLOT_W-1:0]   rd_slot_r;

  logic                out_valid_r;
  out_item_t           out_r;

  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   rd_addr;
  logic                nl_we, pl_we;
  logic [SLOT_W-1:0]   nl_wa, nl_wd, pl_wa, pl_wd;
  logic                multi;

  assign multi = count_r > CNT_W'(1);

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_in_use_r[i]) free_slot = SLOT_W'(i);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = head_r;
      RD_TAIL: rd_addr = tail_r;
      RD_NEXT: rd_addr = rd_next_r;
      RD_NONE: rd_addr = rd_next_r;
    endcase
  end

  // link write ports
  always_comb begin
    nl_we = 1'b0;
    nl_wa = free_slot;
    nl_wd = head_r;
    pl_we = 1'b0;
    pl_wa = head_r;
    pl_wd = free_slot;
    if (cmd.insert) begin
      nl_we = !stat.count_zero;
      pl_we = !stat.count_zero;
    end else if (cmd.unlink && multi) begin
      nl_we = rd_slot_r != head_r;
      nl_wa = rd_prev_r;
      nl_wd = rd_next_r;
      pl_we = rd_slot_r != tail_r;
      pl_wa = rd_next_r;
      pl_wd = rd_prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) key_store[free_slot] <= key_r;
    if (nl_we) next_link[nl_wa] <= nl_wd;
    if (pl_we) prev_link[pl_wa] <= pl_wd;
    if (cmd.rd_sel != RD_NONE) begin
      rd_key_r  <= key_store[rd_addr];
      rd_next_r <= next_link[rd_addr];
      rd_prev_r <= prev_link[rd_addr];
      rd_slot_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) key_r <= in_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_in_use_r <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      idx_r         <= '0;
    end else begin
      if (cmd.insert) begin
        slot_in_use_r[free_slot] <= 1'b1;
        head_r                   <= free_slot;
        if (stat.count_zero) tail_r <= free_slot;
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.unlink) begin
        slot_in_use_r[rd_slot_r] <= 1'b0;
        count_r                  <= count_r - CNT_W'(1);
        if (!multi) begin
          head_r <= '0;
          tail_r <= '0;
        end else begin
          if (rd_slot_r == head_r) head_r <= rd_next_r;
          if (rd_slot_r == tail_r) tail_r <= rd_prev_r;
        end
      end
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + CNT_W'(1);
    end
  end

  assign stat.count_zero = count_r == '0;
  assign stat.count_full = count_r == CNT_W'(CAPACITY);
  assign stat.key_match  = rd_key_r == key_r;
  assign stat.walk_last  = ((CNT_W + 1)'(idx_r) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count_r);
  assign stat.out_space  = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status <= cmd.emit_status;
      out_r.value  <= cmd.emit_dump ? rd_key_r : '0;
      out_r.last   <= cmd.emit_dump ? stat.walk_last : 1'b1;
      out_r.count  <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ src/lldq_ctrl.sv @@
// ----------------------------------------------------------------------------
// lldq_ctrl
// Command sequencer: decodes an item and steps the datapath through it.
// ----------------------------------------------------------------------------
module lldq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_kind,
  output logic               in_ready,
  input  lldq_pkg::dp_stat_t stat,
  output lldq_pkg::dp_cmd_t  cmd
);
  import lldq_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  status_t    st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    st_r   <= st_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    st_nxt    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
          kind_nxt  = in_kind;
        end
      end
      S_DISPATCH: begin
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
        unique case (kind_r)
          K_INSERT: begin
            if (stat.count_full) st_nxt = ST_FULL;
          end
          K_DEL_FIRST, K_DEL_LAST: begin
            if (stat.count_zero) st_nxt = ST_EMPTY;
            else state_nxt = S_UNLINK;
          end
          K_DEL_KEY: begin
            if (stat.count_zero) st_nxt = ST_EMPTY;
            else state_nxt = S_SEARCH;
          end
          K_DUMP: begin
            if (stat.count_zero) st_nxt = ST_EMPTY;
            else state_nxt = S_DUMP;
          end
          default: ;
        endcase
      end
      S_UNLINK: state_nxt = S_EMIT;
      S_SEARCH: begin
        priority if (stat.key_match) begin
          state_nxt = S_UNLINK;
        end else if (stat.walk_last) begin
          st_nxt    = ST_MISSING;
          state_nxt = S_EMIT;
        end
      end
      S_DUMP: begin
        if (stat.out_space && stat.walk_last) state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (stat.out_space) state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_NONE;
    cmd.emit_status = ST_OK;
    in_ready        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DISPATCH: begin
        unique case (kind_r)
          K_INSERT:    cmd.insert = !stat.count_full;
          K_DEL_FIRST: if (!stat.count_zero) cmd.rd_sel = RD_HEAD;
          K_DEL_LAST:  if (!stat.count_zero) cmd.rd_sel = RD_TAIL;
          K_DEL_KEY, K_DUMP: begin
            if (!stat.count_zero) begin
              cmd.rd_sel  = RD_HEAD;
              cmd.idx_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_UNLINK: cmd.unlink = 1'b1;
      S_SEARCH: begin
        // hold the read data on a match so the unlink sees this entry
        if (!stat.key_match && !stat.walk_last) begin
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      S_DUMP: begin
        if (stat.out_space) begin
          cmd.emit      = 1'b1;
          cmd.emit_dump = 1'b1;
          if (!stat.walk_last) begin
            cmd.rd_sel  = RD_NEXT;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_EMIT: begin
        cmd.emit        = stat.out_space;
        cmd.emit_status = st_r;
      end
    endcase
  end

endmodule

@@ src/linked_list_deque_with_key_delete_top.sv @@
// ----------------------------------------------------------------------------
// linked_list_deque_with_key_delete_top
// Bounded doubly linked list of keys with front insert and three deletes.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one command (kind, key).
// Result channel out_valid/out_ready/out_data carries status, value, last and
// the entry count after the command. Every command yields one result, except
// a dump of a non-empty list, which yields one result per entry, front to
// back, with last set on the final one.
// A command is taken only while the sequencer is idle. The sequencer then
// steps through dispatch and emit for insert and unused kinds, adds unlink
// before emit for delete first/last and a search (one list entry compared
// per cycle) before unlink or emit for key delete, and for a dump streams
// one entry per cycle while the receiver accepts; an empty list goes from
// dispatch to emit. The walk rate is set by the registered read port of the
// slot memories. The final result sits in the output register while the
// next command is accepted. If the receiver stalls, the output register
// holds and a dump walk pauses with it; nothing is dropped.
// After reset the list is empty; slot memories are not cleared.
// ----------------------------------------------------------------------------
module linked_list_deque_with_key_delete_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lldq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lldq_pkg::out_item_t out_data
);
  import lldq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lldq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lldq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (in_data.key),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ src/lldq_checker.sv @@
// ----------------------------------------------------------------------------
// lldq_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "linked_list_deque_with_key_delete_top_assert.svh"

module lldq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lldq_pkg::out_item_t out_data
);
  import lldq_pkg::*;

  `LLDQ_ASSERT_IMP(a_count_max, clk, rst_n, out_valid,
                   out_data.count <= CNT_W'(CAPACITY))
  `LLDQ_ASSERT_IMP(a_full_count, clk, rst_n, out_valid && out_data.status == ST_FULL,
                   out_data.count == CNT_W'(CAPACITY) && out_data.last)
  `LLDQ_ASSERT_IMP(a_empty_count, clk, rst_n, out_valid && out_data.status == ST_EMPTY,
                   out_data.count == '0 && out_data.last && out_data.value == '0)
  // only a dump streams more than one transfer, and a dump needs entries
  `LLDQ_ASSERT_IMP(a_mid_dump, clk, rst_n, out_valid && !out_data.last,
                   out_data.status == ST_OK && out_data.count != '0 &&
                   !(in_valid && in_ready))
  `LLDQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind linked_list_deque_with_key_delete_top lldq_checker u_lldq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
